[hdl/b64d_pkg.sv]
// shared types, constants and character classification for the base64 stream decoder
package b64d_pkg;

   // input word: one raw character
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } b64d_req_type;

   // result word: one per input word
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       error;
      logic       done_res;
   } b64d_rsp_type;

   // character kinds seen by the back end
   localparam logic [1:0] KIND_SKIP   = 2'd0;
   localparam logic [1:0] KIND_SEXTET = 2'd1;
   localparam logic [1:0] KIND_PAD    = 2'd2;
   localparam logic [1:0] KIND_ZERO   = 2'd3;

   // classified word passed through the queue
   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] sextet;
      logic       last;
   } b64d_class_type;

   // queue between front and back
   localparam int QUEUE_ADDR_W = 2;
   localparam int QUEUE_DEPTH  = 1 << QUEUE_ADDR_W;

   // alphabet constants
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [5:0] SEXT_PLUS  = 6'd62;
   localparam logic [5:0] SEXT_SLASH = 6'd63;
   localparam logic [5:0] MASK_LO4   = 6'h0F;
   localparam logic [5:0] MASK_LO2   = 6'h03;

   // sort one raw character into its kind and sextet value
   function automatic b64d_class_type classify(input b64d_req_type req);
      b64d_class_type cls;
      cls.last   = req.last;
      cls.sextet = 6'd0;
      cls.kind   = KIND_SKIP;
      if (req.char_code == 8'h00) begin
         cls.kind = KIND_ZERO;
      end else if (req.char_code == CHAR_PAD) begin
         cls.kind = KIND_PAD;
      end else if (req.char_code >= 8'h41 && req.char_code <= 8'h5A) begin
         cls.kind   = KIND_SEXTET;
         cls.sextet = 6'(req.char_code - 8'h41);
      end else if (req.char_code >= 8'h61 && req.char_code <= 8'h7A) begin
         cls.kind   = KIND_SEXTET;
         cls.sextet = 6'(req.char_code - 8'h61 + 8'd26);
      end else if (req.char_code >= 8'h30 && req.char_code <= 8'h39) begin
         cls.kind   = KIND_SEXTET;
         cls.sextet = 6'(req.char_code - 8'h30 + 8'd52);
      end else if (req.char_code == CHAR_PLUS) begin
         cls.kind   = KIND_SEXTET;
         cls.sextet = SEXT_PLUS;
      end else if (req.char_code == CHAR_SLASH) begin
         cls.kind   = KIND_SEXTET;
         cls.sextet = SEXT_SLASH;
      end
      return cls;
   endfunction

endpackage

[hdl/base64_stream_decoder.sv]
// top level of the base64 stream decoder: front end, queue and back end
// an accepted word goes through the front stage, the queue slot and the output slot
// throughput: one input word and one result word per cycle unless stalled, set by
// back-end combinational decode; the four-word queue absorbs stalls on either side
// reset: synchronous, active high; clears the queue, output slot and decode state
module base64_stream_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  b64d_pkg::b64d_req_type req_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output b64d_pkg::b64d_rsp_type rsp_word
);
   import b64d_pkg::*;

   logic           front_valid;
   b64d_class_type front_word;
   logic           queue_full;
   logic           queue_empty;
   logic           queue_pop;
   b64d_class_type queue_word;

   // classify incoming characters
   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cls_valid (front_valid),
      .cls_word  (front_word),
      .cls_full  (queue_full)
   );

   // decouple front and back
   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_word (front_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_word  (queue_word),
      .empty     (queue_empty)
   );

   // decode and present results
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_empty (queue_empty),
      .cls_word  (queue_word),
      .cls_pop   (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

[hdl/b64d_front.sv]
// front end: takes input words, classifies them and hands them to the queue
module b64d_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  b64d_pkg::b64d_req_type  req_word,
   output logic                    cls_valid,
   output b64d_pkg::b64d_class_type cls_word,
   input  logic                    cls_full
);
   import b64d_pkg::*;

   logic           valid_ff, valid_in;
   b64d_class_type word_ff, word_in;
   logic           accept;
   logic           drain;

   // stage holds one classified word until the queue takes it
   assign drain    = valid_ff && !cls_full;
   assign req_full = valid_ff && cls_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (accept) begin
         valid_in = 1'b1;
         word_in  = classify(req_word);
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign cls_valid = valid_ff;
   assign cls_word  = word_ff;

endmodule

[hdl/b64d_queue.sv]
// short queue of classified words between front and back
module b64d_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64d_pkg::b64d_class_type push_word,
   output logic                     full,
   input  logic                     pop,
   output b64d_pkg::b64d_class_type pop_word,
   output logic                     empty
);
   import b64d_pkg::*;

   b64d_class_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_ADDR_W:0]        count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign full    = (count_ff == (QUEUE_ADDR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word = slot_ff[rd_ptr_ff];

endmodule

[hdl/b64d_back.sv]
// back end: runs the decode state and holds the result word for the reader
module b64d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cls_empty,
   input  b64d_pkg::b64d_class_type cls_word,
   output logic                     cls_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output b64d_pkg::b64d_rsp_type   rsp_word
);
   import b64d_pkg::*;

   logic [1:0]   phase_ff, phase_in;
   logic [7:0]   partial_ff, partial_in;
   logic         pad_pending_ff, pad_pending_in;
   logic         failed_ff, failed_in;
   logic         out_valid_ff, out_valid_in;
   b64d_rsp_type out_ff, out_in;
   b64d_rsp_type result;
   logic         take;
   logic         msg_end;
   logic [5:0]   v;

   // take a word when the output slot is free or being emptied
   assign take    = !cls_empty && (!out_valid_ff || rsp_pop);
   assign cls_pop = take;
   assign msg_end = cls_word.last || (cls_word.kind == KIND_ZERO);
   assign v       = cls_word.sextet;

   // decode step for the word at the head of the queue
   always_comb begin
      phase_in       = phase_ff;
      partial_in     = partial_ff;
      pad_pending_in = pad_pending_ff;
      failed_in      = failed_ff;
      result         = '0;
      if (!failed_ff) begin
         if (pad_pending_ff && cls_word.kind != KIND_PAD) begin
            result.error = 1'b1;
            failed_in    = 1'b1;
         end else if (cls_word.kind == KIND_PAD) begin
            if (phase_ff == 2'd1) begin
               if (cls_word.last) begin
                  result.error = 1'b1;
                  failed_in    = 1'b1;
               end else begin
                  pad_pending_in = 1'b1;
               end
            end
         end else if (cls_word.kind == KIND_SEXTET) begin
            unique case (phase_ff)
               2'd0: begin
                  partial_in = {v, 2'b00};
               end
               2'd1: begin
                  result.data_byte  = partial_ff | {6'd0, v[5:4]};
                  result.byte_valid = 1'b1;
                  partial_in        = {(v & MASK_LO4), 2'b00} << 2;
               end
               2'd2: begin
                  result.data_byte  = partial_ff | {4'd0, v[5:2]};
                  result.byte_valid = 1'b1;
                  partial_in        = {(v & MASK_LO2), 2'b00} << 4;
               end
               default: begin
                  result.data_byte  = partial_ff | {2'd0, v};
                  result.byte_valid = 1'b1;
               end
            endcase
            phase_in = phase_ff + 2'd1;
         end
      end
      result.done_res = msg_end;
      // message end returns everything to reset
      if (msg_end) begin
         phase_in       = '0;
         partial_in     = '0;
         pad_pending_in = 1'b0;
         failed_in      = 1'b0;
      end
   end

   // output slot
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         partial_ff     <= '0;
         pad_pending_ff <= 1'b0;
         failed_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            phase_ff       <= phase_in;
            partial_ff     <= partial_in;
            pad_pending_ff <= pad_pending_in;
            failed_ff      <= failed_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   // after a failure nothing is decoded and no further error is raised
   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      take && failed_ff |-> !result.byte_valid && !result.error)
      else $error("decode output while message failed");

   // phase only moves on a sextet or at message end
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      take && cls_word.kind != KIND_SEXTET && !msg_end |=> $stable(phase_ff))
      else $error("phase moved without a sextet");

   // a pending pad always sits at phase one
   a_pad_phase: assert property (@(posedge clock) disable iff (reset)
      pad_pending_ff |-> phase_ff == 2'd1)
      else $error("pad pending away from phase one");

   // a message end leaves clean state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && msg_end |=> phase_ff == 2'd0 && !pad_pending_ff && !failed_ff)
      else $error("state not cleared at message end");

endmodule

[tb/tb.sv]
// self-checking testbench for the base64 stream decoder
`timescale 1ns / 100ps

module tb;
   import b64d_pkg::*;

   localparam logic [7:0] NUL_CHAR = 8'h00;
   localparam int LIVE_CHAR_TARGET = 1250;
   localparam int DIRECTED_ROWS = 25;
   localparam int REPORT_LIMIT = 10;

   // typed-in result words for rows whose outcome is obvious
   localparam b64d_rsp_type RSP_QUIET =
      '{byte_valid: 1'b0, data_byte: 8'h00, error: 1'b0, done_res: 1'b0};
   localparam b64d_rsp_type RSP_ERROR =
      '{byte_valid: 1'b0, data_byte: 8'h00, error: 1'b1, done_res: 1'b0};
   localparam b64d_rsp_type RSP_DONE =
      '{byte_valid: 1'b0, data_byte: 8'h00, error: 1'b0, done_res: 1'b1};
   localparam b64d_rsp_type RSP_ERROR_DONE =
      '{byte_valid: 1'b0, data_byte: 8'h00, error: 1'b1, done_res: 1'b1};

   typedef struct packed {
      logic [7:0]   char_code;
      logic         last;
      logic         has_expected;
      b64d_rsp_type rsp;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   b64d_req_type req_word = '0;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   b64d_rsp_type rsp_word;

   // decoder state mirrored by the testbench
   logic [1:0] dec_phase = 2'd0;
   logic [7:0] dec_partial = 8'h00;
   logic       dec_pad_pending = 1'b0;
   logic       dec_failed = 1'b0;

   b64d_rsp_type     pending_results[$];
   b64d_rsp_type     oldest_result;
   directed_row_type directed_rows [0:DIRECTED_ROWS-1];

   int idle_pct = 8;
   int mismatch_count = 0;
   int live_chars = 0;
   int words_checked = 0;
   int bytes_predicted = 0;
   int errors_predicted = 0;
   int messages_ended = 0;

   base64_stream_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // sextet value of a character, 64 when outside the alphabet
   function automatic logic [6:0] sextet_value(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
      if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
      if (c == CHAR_PLUS) return 7'd62;
      if (c == CHAR_SLASH) return 7'd63;
      return 7'd64;
   endfunction

   // character that carries a given sextet
   function automatic logic [7:0] alphabet_char(input int idx);
      if (idx < 26) return 8'(8'h41 + idx);
      if (idx < 52) return 8'(8'h61 + idx - 26);
      if (idx < 62) return 8'(8'h30 + idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // separator, whitespace or high byte that the decoder skips
   function automatic logic [7:0] filler_char();
      case ($urandom_range(0, 5))
         0: return 8'h20;
         1: return 8'h0A;
         2: return 8'h0D;
         3: return 8'h09;
         4: return 8'h2D;
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   // decode one character and advance the mirrored state
   function automatic b64d_rsp_type decode_char(input b64d_req_type w);
      b64d_rsp_type r;
      logic [6:0]   v;
      logic         msg_end;
      r = '0;
      v = sextet_value(w.char_code);
      msg_end = w.last || w.char_code == NUL_CHAR;
      if (!dec_failed) begin
         if (dec_pad_pending && w.char_code != CHAR_PAD) begin
            // a lone pad after one sextet of a group
            r.error = 1'b1;
            dec_failed = 1'b1;
         end else if (w.char_code == CHAR_PAD) begin
            if (dec_phase == 2'd1) begin
               if (w.last) begin
                  r.error = 1'b1;
                  dec_failed = 1'b1;
               end else begin
                  dec_pad_pending = 1'b1;
               end
            end
         end else if (w.char_code != NUL_CHAR && v < 7'd64) begin
            case (dec_phase)
               2'd0: begin
                  dec_partial = {v[5:0], 2'b00};
               end
               2'd1: begin
                  r.byte_valid = 1'b1;
                  r.data_byte = dec_partial | {6'd0, v[5:4]};
                  dec_partial = {v[3:0], 4'h0};
               end
               2'd2: begin
                  r.byte_valid = 1'b1;
                  r.data_byte = dec_partial | {4'd0, v[5:2]};
                  dec_partial = {v[1:0], 6'd0};
               end
               default: begin
                  r.byte_valid = 1'b1;
                  r.data_byte = dec_partial | {2'd0, v[5:0]};
               end
            endcase
            dec_phase = dec_phase + 2'd1;
         end
      end
      r.done_res = msg_end;
      if (msg_end) begin
         dec_phase = 2'd0;
         dec_partial = 8'h00;
         dec_pad_pending = 1'b0;
         dec_failed = 1'b0;
      end
      return r;
   endfunction

   // offer one character and record what it should produce
   task automatic push_word(input logic [7:0] c, input logic l, input logic has_expected,
                            input b64d_rsp_type fixed_rsp);
      b64d_req_type w;
      b64d_rsp_type predicted;
      w.char_code = c;
      w.last = l;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_full);
      predicted = decode_char(w);
      pending_results.push_back(has_expected ? fixed_rsp : predicted);
      live_chars++;
      if (predicted.byte_valid) bytes_predicted++;
      if (predicted.error) errors_predicted++;
      if (predicted.done_res) messages_ended++;
   endtask

   // one random message: mostly well formed, some with bad padding, some noise
   task automatic send_message();
      logic [7:0] text[$];
      int         mode;
      bit         zero_end;
      mode = $urandom_range(0, 99);
      zero_end = ($urandom_range(0, 9) == 0);
      if (mode < 70) begin
         repeat ($urandom_range(0, 5) * 4) text.push_back(alphabet_char($urandom_range(0, 63)));
         case ($urandom_range(0, 2))
            1: begin
               repeat (3) text.push_back(alphabet_char($urandom_range(0, 63)));
               text.push_back(CHAR_PAD);
            end
            2: begin
               repeat (2) text.push_back(alphabet_char($urandom_range(0, 63)));
               text.push_back(CHAR_PAD);
               text.push_back(CHAR_PAD);
            end
            default: begin
            end
         endcase
      end else if (mode < 85) begin
         repeat ($urandom_range(0, 6)) text.push_back(alphabet_char($urandom_range(0, 63)));
         text.push_back(CHAR_PAD);
         if ($urandom_range(0, 2) == 0) text.push_back(CHAR_PAD);
         repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
      end
      if (zero_end || text.size() == 0) text.push_back(NUL_CHAR);
      foreach (text[i]) begin
         if (mode < 70 && $urandom_range(0, 99) < 8) push_word(filler_char(), 1'b0, 1'b0, '0);
         push_word(text[i], !zero_end && i == text.size() - 1, 1'b0, '0);
      end
   endtask

   // result side stalls at random
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(0, 99) >= idle_pct);
   end

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("tb: unexpected result word %0h at %0t", rsp_word, $realtime);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_word.byte_valid !== oldest_result.byte_valid ||
                rsp_word.data_byte !== oldest_result.data_byte ||
                rsp_word.error !== oldest_result.error ||
                rsp_word.done_res !== oldest_result.done_res) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"tb: word %0d expected valid %0b byte %02h error %0b done %0b,",
                            " got valid %0b byte %02h error %0b done %0b"},
                           words_checked, oldest_result.byte_valid, oldest_result.data_byte,
                           oldest_result.error, oldest_result.done_res, rsp_word.byte_valid,
                           rsp_word.data_byte, rsp_word.error, rsp_word.done_res);
            end
            words_checked++;
         end
      end
   end

   // stimulus
   initial begin
      // directed: alphabet extremes, skipped bytes, pads after 0, 1 and 2 sextets,
      // a pad pair then a letter, a lone last pad, a lone pad then a zero
      directed_rows = '{
         '{8'h41, 1'b0, 1'b1, RSP_QUIET},
         '{CHAR_SLASH, 1'b0, 1'b0, RSP_QUIET},
         '{CHAR_PLUS, 1'b0, 1'b0, RSP_QUIET},
         '{8'h7A, 1'b0, 1'b0, RSP_QUIET},
         '{CHAR_PAD, 1'b0, 1'b1, RSP_QUIET},
         '{8'h5A, 1'b0, 1'b1, RSP_QUIET},
         '{8'hFF, 1'b0, 1'b1, RSP_QUIET},
         '{8'h80, 1'b0, 1'b1, RSP_QUIET},
         '{8'h20, 1'b0, 1'b1, RSP_QUIET},
         '{8'h39, 1'b0, 1'b0, RSP_QUIET},
         '{CHAR_PAD, 1'b0, 1'b1, RSP_QUIET},
         '{8'h30, 1'b0, 1'b0, RSP_QUIET},
         '{8'h61, 1'b1, 1'b0, RSP_QUIET},
         '{8'h51, 1'b0, 1'b1, RSP_QUIET},
         '{CHAR_PAD, 1'b0, 1'b1, RSP_QUIET},
         '{CHAR_PAD, 1'b0, 1'b1, RSP_QUIET},
         '{8'h41, 1'b0, 1'b1, RSP_ERROR},
         '{8'h42, 1'b0, 1'b1, RSP_QUIET},
         '{8'h43, 1'b1, 1'b1, RSP_DONE},
         '{8'h51, 1'b0, 1'b1, RSP_QUIET},
         '{CHAR_PAD, 1'b1, 1'b1, RSP_ERROR_DONE},
         '{8'h51, 1'b0, 1'b1, RSP_QUIET},
         '{CHAR_PAD, 1'b0, 1'b1, RSP_QUIET},
         '{NUL_CHAR, 1'b0, 1'b1, RSP_ERROR_DONE},
         '{NUL_CHAR, 1'b1, 1'b1, RSP_DONE}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         push_word(directed_rows[i].char_code, directed_rows[i].last,
                   directed_rows[i].has_expected, directed_rows[i].rsp);

      // random messages, with a stretch of full-rate traffic in the middle
      while (live_chars < LIVE_CHAR_TARGET) begin
         idle_pct = (live_chars >= 400 && live_chars < 700) ? 0 : 8;
         send_message();
      end
      idle_pct = 8;

      // drain and allow for the pipeline
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("tb: checked %0d result words over %0d messages", words_checked, messages_ended);
      $display("tb: %0d decoded bytes and %0d padding errors predicted",
               bytes_predicted, errors_predicted);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", mismatch_count);
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("tb: timed out");
      $display("tb: failure");
      $finish;
   end

endmodule
